@@ hdl/dvd_pkg.sv @@
// Package for the duplicate value detector: payload structs and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package dvd_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic is_repeat;
    logic any_repeat;
    logic table_full;
    logic end_of_array;
  } result_t;

endpackage

@@ hdl/duplicate_value_detector_unit.sv @@
// Duplicate value detector top level: hash set with linear probing over two RAMs.
// Depends on dvd_pkg and dvd_ram.
`timescale 1ns / 1ps

// Each item is one array element; each gives one result saying whether the value
// was seen earlier in the array, whether any repeat has been seen so far, and
// whether a new value was dropped because the table is full. An item is accepted
// and then the key RAM is probed one slot at a time from the home slot until a
// slot is empty or holds the value, or every slot of a full table was probed.
// After the last item of an array the slots that were filled are cleared
// from a list of used slots, one per cycle. After reset a clearing pass
// over every slot of the key RAM runs before the first item is taken.
module duplicate_value_detector_unit #(
  parameter int TABLE_DEPTH = dvd_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  dvd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output dvd_pkg::result_t result
);

  import dvd_pkg::*;

  localparam int W      = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int NCHUNK = (32 + W - 1) / W;
  localparam logic [W-1:0] LAST_SLOT = W'(TABLE_DEPTH - 1);
  localparam logic [W:0]   DEPTH_X   = (W + 1)'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [W-1:0]  slot, slot_next;
  logic [W-1:0]  probes, probes_next;
  logic [31:0]   key, key_next;
  logic          last_r, last_r_next;
  logic          repeat_seen, repeat_seen_next;
  logic [CW-1:0] entries_used, entries_used_next;
  logic [W-1:0]  init_idx, init_idx_next;
  logic [CW-1:0] clr_idx, clr_idx_next;
  logic [CW-1:0] clr_cnt, clr_cnt_next;
  logic          clr_vld, clr_vld_next;
  result_t       res_pend, res_pend_next;
  logic          out_valid, out_valid_next;
  result_t       out_data, out_data_next;

  logic          key_we;
  logic [W-1:0]  key_waddr;
  logic [32:0]   key_wdata;
  logic [W-1:0]  key_raddr;
  logic [32:0]   key_rdata;
  logic          list_we;
  logic [W-1:0]  list_waddr;
  logic [W-1:0]  list_wdata;
  logic [W-1:0]  list_raddr;
  logic [W-1:0]  list_rdata;

  logic [31:0]   fold_sh;
  logic [W-1:0]  fold;
  logic [W:0]    fold_x;
  logic [W-1:0]  home;
  logic [W-1:0]  slot_inc;
  logic          resolved;
  logic          found;
  logic          full;
  logic          placed;
  logic          rep;
  result_t       res;

  dvd_ram #(.WIDTH(33), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  dvd_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  // xor-fold of the value down to the index width, reduced below the depth
  always_comb begin
    fold    = '0;
    fold_sh = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      fold_sh = item.value >> (i * W);
      fold    = fold ^ fold_sh[W-1:0];
    end
    fold_x = {1'b0, fold};
    if (fold_x >= DEPTH_X) begin
      fold_x = fold_x - DEPTH_X;
    end
    home = fold_x[W-1:0];
  end

  assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + 1'b1;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_valid;
  assign result       = out_data;

  always_comb begin
    state_next        = state;
    slot_next         = slot;
    probes_next       = probes;
    key_next          = key;
    last_r_next       = last_r;
    repeat_seen_next  = repeat_seen;
    entries_used_next = entries_used;
    init_idx_next     = init_idx;
    clr_idx_next      = clr_idx;
    clr_cnt_next      = clr_cnt;
    clr_vld_next      = clr_vld;
    res_pend_next     = res_pend;
    out_valid_next    = out_valid && !result_ready;
    out_data_next     = out_data;

    key_we     = 1'b0;
    key_waddr  = slot;
    key_wdata  = {1'b1, key};
    key_raddr  = slot;
    list_we    = 1'b0;
    list_waddr = entries_used[W-1:0];
    list_wdata = slot;
    list_raddr = clr_idx[W-1:0];

    resolved = 1'b0;
    found    = 1'b0;
    full     = 1'b0;
    placed   = 1'b0;
    rep      = repeat_seen;
    res      = '0;

    unique case (state)
      S_INIT: begin
        key_we    = 1'b1;
        key_waddr = init_idx;
        key_wdata = '0;
        if (init_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end else begin
          init_idx_next = init_idx + 1'b1;
        end
      end

      S_IDLE: begin
        key_raddr = home;
        if (item_valid) begin
          key_next    = item.value;
          last_r_next = item.last;
          slot_next   = home;
          probes_next = '0;
          state_next  = S_LOOK;
        end
      end

      S_LOOK: begin
        if (!key_rdata[32]) begin
          placed            = 1'b1;
          resolved          = 1'b1;
          key_we            = 1'b1;
          list_we           = 1'b1;
          entries_used_next = entries_used + 1'b1;
        end else if (key_rdata[31:0] == key) begin
          found    = 1'b1;
          resolved = 1'b1;
        end else if (probes == LAST_SLOT) begin
          full     = 1'b1;
          resolved = 1'b1;
        end else begin
          slot_next   = slot_inc;
          probes_next = probes + 1'b1;
          key_raddr   = slot_inc;
        end

        if (resolved) begin
          rep              = repeat_seen | found;
          res.is_repeat    = found;
          res.any_repeat   = rep;
          res.table_full   = full;
          res.end_of_array = last_r;
          repeat_seen_next = rep;
          if (last_r) begin
            repeat_seen_next  = 1'b0;
            entries_used_next = '0;
            clr_cnt_next      = entries_used + CW'(placed);
            clr_idx_next      = '0;
            clr_vld_next      = 1'b0;
          end
          if (!out_valid || result_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
            state_next     = last_r ? S_CLEAR : S_IDLE;
          end else begin
            res_pend_next = res;
            state_next    = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        if (!out_valid || result_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res_pend;
          state_next     = res_pend.end_of_array ? S_CLEAR : S_IDLE;
        end
      end

      S_CLEAR: begin
        if (clr_idx != clr_cnt) begin
          clr_idx_next = clr_idx + 1'b1;
          clr_vld_next = 1'b1;
        end else begin
          clr_vld_next = 1'b0;
        end
        if (clr_vld) begin
          key_we    = 1'b1;
          key_waddr = list_rdata;
          key_wdata = '0;
        end
        if (clr_idx == clr_cnt && !clr_vld) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_idx     <= '0;
      repeat_seen  <= 1'b0;
      entries_used <= '0;
      clr_idx      <= '0;
      clr_cnt      <= '0;
      clr_vld      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      init_idx     <= init_idx_next;
      repeat_seen  <= repeat_seen_next;
      entries_used <= entries_used_next;
      clr_idx      <= clr_idx_next;
      clr_cnt      <= clr_cnt_next;
      clr_vld      <= clr_vld_next;
      out_valid    <= out_valid_next;
    end
    slot     <= slot_next;
    probes   <= probes_next;
    key      <= key_next;
    last_r   <= last_r_next;
    res_pend <= res_pend_next;
    out_data <= out_data_next;
  end

endmodule

@@ hdl/dvd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ bench/tb.sv @@
// Testbench for duplicate_value_detector_unit: random and directed arrays of values,
// checked against an in-bench hash set model with linear probing.
// Depends on dvd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb;
  import dvd_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int RANDOM_ITEMS = 150;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  duplicate_value_detector_unit #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // hash set model
  logic [31:0] slot_keys [DEPTH];
  bit          slot_used [DEPTH];
  bit          repeat_flag = 1'b0;

  item_t   pending_items [$];
  result_t expected_results [$];

  int unsigned total_items = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned arrays_done = 0;
  int unsigned repeats_seen = 0;
  int unsigned full_seen = 0;
  int unsigned errors = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic result_t lookup_insert(item_t it);
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] h;
    int          slot;
    int          n;
    bit          found;
    bit          placed;
    result_t     r;
    key = it.value;
    mask = (32'd1 << IDX_W) - 32'd1;
    h = '0;
    for (int s = 0; s < 32; s += IDX_W)
      h ^= (key >> s) & mask;
    while (h >= DEPTH)
      h -= DEPTH;
    slot = int'(h);
    found = 1'b0;
    placed = 1'b0;
    n = 0;
    while (n < DEPTH && !found && !placed) begin
      if (!slot_used[slot]) begin
        slot_keys[slot] = key;
        slot_used[slot] = 1'b1;
        placed = 1'b1;
      end else if (slot_keys[slot] == key) begin
        found = 1'b1;
      end else begin
        slot = (slot + 1 == DEPTH) ? 0 : slot + 1;
      end
      n++;
    end
    repeat_flag |= found;
    r.is_repeat = found;
    r.any_repeat = repeat_flag;
    r.table_full = !found && !placed;
    r.end_of_array = it.last;
    if (it.last) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      repeat_flag = 1'b0;
    end
    return r;
  endfunction

  function automatic int send_idle_pct();
    if (items_sent < total_items / 3) return 6;
    if (items_sent < 2 * total_items / 3) return 78;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (items_sent < total_items / 3) return 78;
    if (items_sent < 2 * total_items / 3) return 6;
    return 0;
  endfunction

  task automatic push_item(logic [31:0] v, bit l);
    item_t x;
    x.value = v;
    x.last = l;
    pending_items.push_back(x);
  endtask

  task automatic check_field(string name, bit exp_v, bit act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp_v, act_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(lookup_insert(item));
        items_sent++;
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no item pending, got %b", $time, result);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("is_repeat", exp_r.is_repeat, result.is_repeat);
          check_field("any_repeat", exp_r.any_repeat, result.any_repeat);
          check_field("table_full", exp_r.table_full, result.table_full);
          check_field("end_of_array", exp_r.end_of_array, result.end_of_array);
        end
        results_checked++;
        if (result.end_of_array) arrays_done++;
        if (result.is_repeat) repeats_seen++;
        if (result.table_full) full_seen++;
      end
      // long hold-off to back the block up
      if (!stall_done && results_checked >= 300) begin
        stall_left = 400;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  initial begin
    logic [31:0] v;
    logic [31:0] base;
    logic [31:0] prev;
    logic [31:0] d;
    logic [31:0] pool [8];
    int          r;
    int          len;
    int          random_items;
    bit          b1;
    bit          b2;

    foreach (slot_used[i]) slot_used[i] = 1'b0;

    // extremes and repeats
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b1);
    // collisions on the top slot, probe wraps to slot 0
    push_item(32'd1023, 1'b0);
    push_item(32'd1023 ^ 32'h0000_0401, 1'b0);
    push_item(32'd1023 ^ 32'h0000_0802, 1'b0);
    push_item(32'd1023 ^ 32'h0000_0C03, 1'b0);
    push_item(32'd0, 1'b0);
    push_item(32'd1023 ^ 32'h0000_0802, 1'b0);
    push_item(32'd5, 1'b1);
    // set is empty again after the last item
    push_item(32'h8000_0000, 1'b1);
    push_item(32'd7, 1'b0);
    push_item(32'd7, 1'b1);
    // fill every slot, then new values are dropped
    for (int i = 0; i < DEPTH; i++)
      push_item(i, 1'b0);
    push_item(32'h0000_0400, 1'b0);
    push_item(32'h0000_0400, 1'b0);
    push_item(32'd5, 1'b0);
    push_item(32'hDEAD_BEEF, 1'b1);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(9);
      len = (r < 6) ? $urandom_range(12, 1) :
            (r < 9) ? $urandom_range(60, 13) : $urandom_range(300, 61);
      if (len > RANDOM_ITEMS - random_items) len = RANDOM_ITEMS - random_items;
      base = ($urandom_range(3) == 0) ? 32'd1020 + $urandom_range(3) : $urandom;
      for (int k = 0; k < 8; k++) pool[k] = $urandom;
      prev = base;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(4))
          0: v = $urandom;
          1: v = pool[$urandom_range(7)];
          2: begin
            d = $urandom_range(1023);
            v = base ^ ((d << 10) | d);
          end
          3: v = prev;
          default: begin
            b1 = 1'($urandom_range(1));
            b2 = 1'($urandom_range(1));
            v = {b1, {31{b2}}};
          end
        endcase
        push_item(v, i == len - 1);
        prev = v;
        random_items++;
      end
    end
    total_items = pending_items.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("Sent %0d items in %0d arrays; %0d repeats and %0d full-table drops reported.",
             items_sent, arrays_done, repeats_seen, full_seen);
    $display("Covered field extremes, probe wrap, a full table and a long output stall.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
